// ----- hw/rtl/rei_pkg.sv -----
package rei_pkg;

  typedef enum logic [2:0] {
    EV_COPY  = 3'd0,
    EV_INS   = 3'd1,
    EV_SUB   = 3'd2,
    EV_DEL   = 3'd3,
    EV_BLOCK = 3'd4,
    EV_FIN   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOAD = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_t;

  typedef enum logic [1:0] {
    REG_PROB_INSERT = 2'd0,
    REG_PROB_SUB    = 2'd1,
    REG_PROB_DELETE = 2'd2,
    REG_PAD_TRIM    = 2'd3
  } reg_index_t;

  localparam int PROB_W = 16;
  localparam int PAD_W  = 11;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;

  typedef struct packed {
    event_t             ev;
    logic [POS_W-1:0]   position;
    logic [1:0]         out_base;
    logic [1:0]         orig_base;
    logic [LEN_W-1:0]   final_length;
  } result_t;

  typedef struct packed {
    logic out_inc;
    logic src_inc;
    logic room_dec;
    logic finish;
  } advance_t;

endpackage

// ----- hw/rtl/rei_store.sv -----
module rei_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [1:0]    rd_data_a,
  output logic [1:0]    rd_data_b
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- hw/rtl/rei_step.sv -----
module rei_step import rei_pkg::*; #(
  parameter int MAX_READ = 1024,
  parameter int CW       = 11
) (
  input  logic [PROB_W-1:0] prob_insert,
  input  logic [PROB_W-1:0] prob_substitute,
  input  logic [PROB_W-1:0] prob_delete,
  input  logic [PAD_W-1:0]  pad_trim,
  input  logic [CW-1:0]     source_count,
  input  logic [CW-1:0]     out_index,
  input  logic [CW-1:0]     src_index,
  input  logic [PAD_W-1:0]  deletion_room,
  input  logic [15:0]       draw,
  input  logic [1:0]        insert_base,
  input  logic [1:0]        sub_offset,
  input  logic [1:0]        src_word,
  input  logic [1:0]        blk_word,
  output result_t           res,
  output advance_t          adv
);

  localparam int MW = (CW > PAD_W) ? CW : PAD_W;

  logic [MW-1:0] count_x;
  logic [MW-1:0] pad_x;
  logic [MW-1:0] out_x;
  logic [MW-1:0] src_x;
  logic [MW-1:0] limit;
  logic [16:0]   t1;
  logic [16:0]   t2;
  logic [17:0]   t3;
  logic          fin;
  logic          del_ok;
  logic [1:0]    sub_word;

  assign count_x  = MW'(source_count);
  assign pad_x    = MW'(pad_trim);
  assign out_x    = MW'(out_index);
  assign src_x    = MW'(src_index);
  assign limit    = (count_x > pad_x) ? (count_x - pad_x) : '0;
  assign t1       = {1'b0, prob_insert};
  assign t2       = {1'b0, prob_insert} + {1'b0, prob_substitute};
  assign t3       = {1'b0, t2} + {2'b00, prob_delete};
  assign fin      = (out_x >= limit) || (src_x >= count_x) || (out_x >= MW'(MAX_READ));
  assign del_ok   = (out_index != '0) && ((pad_trim == '0) || (deletion_room != '0));
  assign sub_word = 2'(src_word + 2'd1 + sub_offset);

  always_comb begin
    res.ev           = EV_COPY;
    res.position     = out_x[POS_W-1:0];
    res.out_base     = src_word;
    res.orig_base    = src_word;
    res.final_length = '0;
    adv              = '0;
    if (fin) begin
      res.ev           = EV_FIN;
      res.position     = '0;
      res.out_base     = '0;
      res.orig_base    = '0;
      res.final_length = out_x[LEN_W-1:0];
      adv.finish       = 1'b1;
    end else if ({1'b0, draw} < t1) begin
      res.ev        = EV_INS;
      res.out_base  = insert_base;
      res.orig_base = '0;
      adv.out_inc   = 1'b1;
    end else if ({1'b0, draw} < t2) begin
      res.ev      = EV_SUB;
      res.out_base = sub_word;
      adv.out_inc = 1'b1;
      adv.src_inc = 1'b1;
    end else if ({2'b00, draw} < t3) begin
      if (del_ok) begin
        res.ev       = EV_DEL;
        res.out_base = '0;
        adv.src_inc  = 1'b1;
        adv.room_dec = (deletion_room != '0);
      end else begin
        res.ev        = EV_BLOCK;
        res.out_base  = blk_word;
        res.orig_base = '0;
        adv.out_inc   = 1'b1;
      end
    end else begin
      adv.out_inc = 1'b1;
      adv.src_inc = 1'b1;
    end
  end

endmodule

// ----- hw/rtl/read_error_injector.sv -----
// Sequencing-error injector for one read of 2-bit bases. A load word (kind 0) writes one
// base into the source memory if it holds fewer than MAX_READ; the word with load_last
// set starts a run. For a step word (kind 1) during a run, busy is high in the cycle
// after acceptance while the source memory read returns, and the result follows
// on the next cycle with done high for exactly that cycle. The receiver cannot stall,
// so results must be taken when done is high. A step outside a run gives no result and
// does not raise busy. Configuration writes are accepted in any cycle (cfg_ready is
// always high) and should be made while no step is in progress.
module read_error_injector import rei_pkg::*; #(
  parameter int MAX_READ = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [1:0]        src_base,
  input  logic              load_last,
  input  logic [15:0]       draw,
  input  logic [1:0]        insert_base,
  input  logic [1:0]        sub_offset,
  output logic              done,
  output logic [2:0]        event_res,
  output logic [POS_W-1:0]  position,
  output logic [1:0]        out_base,
  output logic [1:0]        orig_base,
  output logic [LEN_W-1:0]  final_length,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [PROB_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_READ + 1);
  localparam int AW = $clog2(MAX_READ);

  logic [PROB_W-1:0] prob_insert;
  logic [PROB_W-1:0] prob_substitute;
  logic [PROB_W-1:0] prob_delete;
  logic [PAD_W-1:0]  pad_trim;

  phase_t            phase;
  phase_t            phase_next;
  ctl_state_t        state;
  ctl_state_t        state_next;
  logic [CW-1:0]     source_count;
  logic [CW-1:0]     source_count_next;
  logic [CW-1:0]     out_index;
  logic [CW-1:0]     out_index_next;
  logic [CW-1:0]     src_index;
  logic [CW-1:0]     src_index_next;
  logic [PAD_W-1:0]  deletion_room;
  logic [PAD_W-1:0]  deletion_room_next;

  logic [15:0]       draw_q;
  logic [1:0]        insert_base_q;
  logic [1:0]        sub_offset_q;
  result_t           res_q;

  logic              accept;
  logic              load_go;
  logic              step_go;
  logic [CW-1:0]     load_base;
  logic              wr_en;
  logic [1:0]        src_word;
  logic [1:0]        blk_word;
  result_t           res;
  advance_t          adv;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign load_go   = accept && !kind;
  assign step_go   = accept && kind && (phase == PH_RUN);
  assign load_base = (phase == PH_LOAD) ? source_count : '0;
  assign wr_en     = load_go && (load_base < CW'(MAX_READ));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prob_insert     <= '0;
      prob_substitute <= '0;
      prob_delete     <= '0;
      pad_trim        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_PROB_INSERT: prob_insert     <= cfg_data;
        REG_PROB_SUB:    prob_substitute <= cfg_data;
        REG_PROB_DELETE: prob_delete     <= cfg_data;
        REG_PAD_TRIM:    pad_trim        <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  rei_store #(
    .DEPTH (MAX_READ),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (load_base[AW-1:0]),
    .wr_data   (src_base),
    .rd_addr_a (src_index[AW-1:0]),
    .rd_addr_b (out_index[AW-1:0]),
    .rd_data_a (src_word),
    .rd_data_b (blk_word)
  );

  rei_step #(
    .MAX_READ (MAX_READ),
    .CW       (CW)
  ) u_step (
    .prob_insert     (prob_insert),
    .prob_substitute (prob_substitute),
    .prob_delete     (prob_delete),
    .pad_trim        (pad_trim),
    .source_count    (source_count),
    .out_index       (out_index),
    .src_index       (src_index),
    .deletion_room   (deletion_room),
    .draw            (draw_q),
    .insert_base     (insert_base_q),
    .sub_offset      (sub_offset_q),
    .src_word        (src_word),
    .blk_word        (blk_word),
    .res             (res),
    .adv             (adv)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: if (step_go) state_next = CTL_EXEC;
      CTL_EXEC: state_next = CTL_IDLE;
      default:  state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    unique case (state)
      CTL_IDLE: busy = 1'b0;
      CTL_EXEC: busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    source_count_next  = source_count;
    out_index_next     = out_index;
    src_index_next     = src_index;
    deletion_room_next = deletion_room;
    if (load_go) begin
      phase_next        = PH_LOAD;
      source_count_next = wr_en ? (load_base + CW'(1)) : load_base;
      if (load_last) begin
        out_index_next     = '0;
        src_index_next     = '0;
        deletion_room_next = pad_trim;
        phase_next         = PH_RUN;
      end
    end else if (state == CTL_EXEC) begin
      if (adv.finish) phase_next = PH_IDLE;
      if (adv.out_inc) out_index_next = out_index + CW'(1);
      if (adv.src_inc) src_index_next = src_index + CW'(1);
      if (adv.room_dec) deletion_room_next = deletion_room - PAD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CTL_IDLE;
      phase         <= PH_IDLE;
      source_count  <= '0;
      out_index     <= '0;
      src_index     <= '0;
      deletion_room <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      source_count  <= source_count_next;
      out_index     <= out_index_next;
      src_index     <= src_index_next;
      deletion_room <= deletion_room_next;
      done          <= (state == CTL_EXEC);
    end
  end

  // step word capture and result register
  always_ff @(posedge clk) begin
    if (step_go) begin
      draw_q        <= draw;
      insert_base_q <= insert_base;
      sub_offset_q  <= sub_offset;
    end
    if (state == CTL_EXEC) begin
      res_q <= res;
    end
  end

  assign event_res    = res_q.ev;
  assign position     = res_q.position;
  assign out_base     = res_q.out_base;
  assign orig_base    = res_q.orig_base;
  assign final_length = res_q.final_length;

endmodule
